@@ hw/rtl/csd_pkg.sv @@
package csd_pkg;

    localparam int FACE_W  = 3;
    localparam int LEVEL_W = 5;
    localparam int COORD_W = 28;
    localparam int ID_W    = 64;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DIR   = 2'd1,
        ST_LEVEL_HIGH = 2'd2
    } status_t;

    // per-item control carried from classifier to divider pipeline
    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [LEVEL_W-1:0] level;
        status_t            status;
        logic               edge_u;   // u equals the major magnitude
        logic               edge_v;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

@@ hw/rtl/csd_front.sv @@
module csd_front
    import csd_pkg::*;
#(
    parameter int COMP_WIDTH = 32,
    parameter int MAX_LEVEL  = 28
)
(
    input  logic [31:0]          dir_x,
    input  logic [31:0]          dir_y,
    input  logic [31:0]          dir_z,
    input  logic [LEVEL_W-1:0]   subdiv_level,
    output meta_t                meta,
    output logic [COMP_WIDTH:0]  rem_u,
    output logic [COMP_WIDTH:0]  rem_v,
    output logic [COMP_WIDTH:0]  den
);

    localparam int W = COMP_WIDTH;

    logic signed [W:0]   xe, ye, ze;
    logic        [W:0]   ax, ay, az;
    logic signed [W:0]   u, v;
    logic        [W:0]   m;
    logic        [W+1:0] num_u, num_v, den_w;
    logic [FACE_W-1:0]   face;

    always_comb
    begin
        xe = (W+1)'(signed'(dir_x[W-1:0]));
        ye = (W+1)'(signed'(dir_y[W-1:0]));
        ze = (W+1)'(signed'(dir_z[W-1:0]));
        ax = xe[W] ? (W+1)'(-xe) : xe;
        ay = ye[W] ? (W+1)'(-ye) : ye;
        az = ze[W] ? (W+1)'(-ze) : ze;

        // major axis, ties to x then y
        if (ax >= ay && ax >= az)
        begin
            m = ax;
            if (!xe[W] && xe != '0)
            begin
                face = FACE_POS_X; u = ye;  v = ze;
            end
            else
            begin
                face = FACE_NEG_X; u = -ye; v = ze;
            end
        end
        else if (ay >= az)
        begin
            m = ay;
            if (!ye[W])
            begin
                face = FACE_POS_Y; u = -xe; v = ze;
            end
            else
            begin
                face = FACE_NEG_Y; u = xe;  v = ze;
            end
        end
        else
        begin
            m = az;
            if (!ze[W])
            begin
                face = FACE_POS_Z; u = ye; v = -xe;
            end
            else
            begin
                face = FACE_NEG_Z; u = ye; v = xe;
            end
        end

        num_u = (W+2)'(u) + (W+2)'(m);
        num_v = (W+2)'(v) + (W+2)'(m);
        den_w = {m, 1'b0};
        den   = den_w[W:0];

        meta.face   = face;
        meta.level  = subdiv_level;
        meta.edge_u = (num_u == den_w);
        meta.edge_v = (num_v == den_w);
        if (subdiv_level > LEVEL_W'(MAX_LEVEL))
            meta.status = ST_LEVEL_HIGH;
        else if (ax == '0 && ay == '0 && az == '0)
            meta.status = ST_ZERO_DIR;
        else
            meta.status = ST_OK;

        // ratio of exactly one is clamped later; start its division from zero
        rem_u = meta.edge_u ? '0 : num_u[W:0];
        rem_v = meta.edge_v ? '0 : num_v[W:0];
    end

endmodule

@@ hw/rtl/csd_queue.sv @@
module csd_queue
    import csd_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_stall,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_pop,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              push, pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hw/rtl/csd_back.sv @@
module csd_back
    import csd_pkg::*;
#(
    parameter int COMP_WIDTH = 32,
    parameter int MAX_LEVEL  = 28
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    output logic                head_pop,
    input  meta_t               head_meta,
    input  logic [COMP_WIDTH:0] head_rem_u,
    input  logic [COMP_WIDTH:0] head_rem_v,
    input  logic [COMP_WIDTH:0] head_den,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     cell_id,
    output logic [FACE_W-1:0]   cube_face,
    output logic [COORD_W-1:0]  cell_x,
    output logic [COORD_W-1:0]  cell_y,
    output logic [1:0]          status
);

    localparam int RW = COMP_WIDTH + 1;
    localparam int QW = MAX_LEVEL;

    logic          vld_reg  [QW];
    meta_t         meta_reg [QW];
    logic [RW-1:0] den_reg  [QW];
    logic [RW-1:0] ru_reg   [QW];
    logic [RW-1:0] rv_reg   [QW];
    logic [QW-1:0] qu_reg   [QW];
    logic [QW-1:0] qv_reg   [QW];

    logic [RW-1:0] ru_next  [QW];
    logic [RW-1:0] rv_next  [QW];
    logic [QW-1:0] qu_next  [QW];
    logic [QW-1:0] qv_next  [QW];

    logic                 out_valid_reg;
    logic [ID_W-1:0]      cell_id_reg;
    logic [FACE_W-1:0]    face_reg;
    logic [COORD_W-1:0]   cx_reg, cy_reg;
    status_t              status_reg;

    logic                 advance;
    meta_t                tail;
    logic [LEVEL_W-1:0]   sh;
    logic [QW-1:0]        cx_q, cy_q;
    logic [COORD_W-1:0]   cx_next, cy_next;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                             input logic [RW-1:0] d);
        logic [RW:0] t;
        t = {rem, 1'b0};
        if (t >= {1'b0, d})
            div_step = {1'b1, RW'(t - {1'b0, d})};
        else
            div_step = {1'b0, rem[RW-2:0], 1'b0};
    endfunction

    assign advance  = !out_valid_reg || !out_stall;
    assign head_pop = advance;

    always_comb
    begin
        logic [RW:0] su, sv;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                su = div_step(head_rem_u, head_den);
                sv = div_step(head_rem_v, head_den);
                qu_next[k] = QW'(su[RW]);
                qv_next[k] = QW'(sv[RW]);
            end
            else
            begin
                su = div_step(ru_reg[k-1], den_reg[k-1]);
                sv = div_step(rv_reg[k-1], den_reg[k-1]);
                qu_next[k] = (qu_reg[k-1] << 1) | QW'(su[RW]);
                qv_next[k] = (qv_reg[k-1] << 1) | QW'(sv[RW]);
            end
            ru_next[k] = su[RW-1:0];
            rv_next[k] = sv[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= head_valid;
            for (int k = 1; k < QW; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta_reg[0] <= head_meta;
            den_reg[0]  <= head_den;
            for (int k = 1; k < QW; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end
            for (int k = 0; k < QW; k++)
            begin
                ru_reg[k] <= ru_next[k];
                rv_reg[k] <= rv_next[k];
                qu_reg[k] <= qu_next[k];
                qv_reg[k] <= qv_next[k];
            end
        end
    end

    // keep the top level bits of the fraction; clamp a ratio of one
    always_comb
    begin
        tail = meta_reg[QW-1];
        sh   = LEVEL_W'(MAX_LEVEL) - tail.level;
        cx_q = tail.edge_u ? ({QW{1'b1}} >> sh) : (qu_reg[QW-1] >> sh);
        cy_q = tail.edge_v ? ({QW{1'b1}} >> sh) : (qv_reg[QW-1] >> sh);
        if (tail.status == ST_OK)
        begin
            cx_next = COORD_W'(cx_q);
            cy_next = COORD_W'(cy_q);
        end
        else
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= tail.status;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            if (tail.status == ST_OK)
            begin
                face_reg    <= tail.face;
                cell_id_reg <= {tail.face, tail.level, cx_next, cy_next};
            end
            else
            begin
                face_reg    <= '0;
                cell_id_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_id   = cell_id_reg;
    assign cube_face = face_reg;
    assign cell_x    = cx_reg;
    assign cell_y    = cy_reg;
    assign status    = status_reg;

endmodule

@@ hw/rtl/cube_sphere_direction_to_cell_unit.sv @@
// Cube-sphere direction to cell: takes a direction (three signed components of
// any scale, read from their low COMP_WIDTH bits) and a subdivision level, and
// returns the cube face, the two quantized face coordinates and the packed cell
// identifier face<<61 | level<<56 | x<<28 | y. One transfer is taken per cycle
// and one result leaves per cycle while nothing stalls; results come from the
// restoring divider pipeline, which yields one quotient bit per stage, and are
// registered at the output. A two-entry queue sits between classifier and
// divider, so after the output side stalls the input side keeps taking
// transfers until both queue entries are full (one more transfer in steady
// flow, two from an empty queue). Status 2 (level too high) wins over status 1
// (zero direction); on either error all other fields are zero.
module cube_sphere_direction_to_cell_unit
    import csd_pkg::*;
#(
    parameter int COMP_WIDTH = 32,
    parameter int MAX_LEVEL  = 28
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         dir_x,
    input  logic [31:0]         dir_y,
    input  logic [31:0]         dir_z,
    input  logic [LEVEL_W-1:0]  subdiv_level,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     cell_id,
    output logic [FACE_W-1:0]   cube_face,
    output logic [COORD_W-1:0]  cell_x,
    output logic [COORD_W-1:0]  cell_y,
    output logic [1:0]          status
);

    localparam int RW = COMP_WIDTH + 1;
    localparam int QD = META_W + 3 * RW;

    // classifier outputs
    meta_t          f_meta;
    logic [RW-1:0]  f_rem_u, f_rem_v, f_den;

    // queue head
    logic           h_valid, h_pop;
    logic [QD-1:0]  h_data;
    meta_t          h_meta;
    logic [RW-1:0]  h_rem_u, h_rem_v, h_den;

    // front: sign-extend, pick face, form numerators and divisor
    csd_front #(
        .COMP_WIDTH (COMP_WIDTH),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_front (
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .subdiv_level (subdiv_level),
        .meta         (f_meta),
        .rem_u        (f_rem_u),
        .rem_v        (f_rem_v),
        .den          (f_den)
    );

    // decouples input transfers from divider stalls
    csd_queue #(
        .DATA_W (QD)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_stall (in_stall),
        .wr_data  ({f_meta, f_rem_u, f_rem_v, f_den}),
        .rd_valid (h_valid),
        .rd_pop   (h_pop),
        .rd_data  (h_data)
    );

    assign {h_meta, h_rem_u, h_rem_v, h_den} = h_data;

    // back: two dividers, one bit per stage, then the output register
    csd_back #(
        .COMP_WIDTH (COMP_WIDTH),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (h_valid),
        .head_pop   (h_pop),
        .head_meta  (h_meta),
        .head_rem_u (h_rem_u),
        .head_rem_v (h_rem_v),
        .head_den   (h_den),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_id    (cell_id),
        .cube_face  (cube_face),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .status     (status)
    );

    // error results carry nothing but the status
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> cell_id == '0 && cell_x == '0 && cell_y == '0)
        else $error("error result with non-zero payload");

    // coordinates stay below 2^level
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK
        |-> (cell_x >> cell_id[60:56]) == '0 && (cell_y >> cell_id[60:56]) == '0)
        else $error("coordinate beyond level range");

    // packed identifier agrees with the separate fields
    a_pack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK
        |-> cell_id[63:61] == cube_face && cell_id[55:28] == cell_x
            && cell_id[27:0] == cell_y)
        else $error("packed identifier mismatch");

    // input only stalls once the queue is full and the divider held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> h_valid && $past(!h_pop || h_valid))
        else $error("input stalled with queue not full");

endmodule

@@ test/tb_cube_sphere_direction_to_cell_unit.sv @@
module tb_cube_sphere_direction_to_cell_unit;
    import csd_pkg::*;

    localparam int MAX_LVL = 28;
    localparam int LATENCY = MAX_LVL + 1;

    // one expected cell per accepted transfer
    typedef struct {
        logic [ID_W-1:0]    id;
        logic [FACE_W-1:0]  face;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [1:0]         st;
    } cell_t;

    // quantise a/m onto 2^level steps, clamping the far edge
    function automatic logic [63:0] quantise_coord(longint a, longint m, int level);
        logic [63:0] n;
        logic [63:0] q;
        begin
            n = 64'd1 << level;
            q = (64'(a + m) << level) / (64'(m) * 2);
            return (q > n - 1) ? n - 1 : q;
        end
    endfunction

    function automatic cell_t locate_cell(logic [31:0] dx, logic [31:0] dy,
                                          logic [31:0] dz, logic [4:0] lvl);
        cell_t   c;
        longint  x;
        longint  y;
        longint  z;
        longint  ax;
        longint  ay;
        longint  az;
        longint  m;
        longint  u;
        longint  v;
        begin
            c = '{default: '0};
            x = longint'($signed(dx));
            y = longint'($signed(dy));
            z = longint'($signed(dz));
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = z < 0 ? -z : z;
            if (lvl > MAX_LVL)
            begin
                c.st = ST_LEVEL_HIGH;
                return c;
            end
            if (ax == 0 && ay == 0 && az == 0)
            begin
                c.st = ST_ZERO_DIR;
                return c;
            end
            if (ax >= ay && ax >= az)
            begin
                m = ax;
                if (x > 0)
                begin
                    c.face = FACE_POS_X; u = y; v = z;
                end
                else
                begin
                    c.face = FACE_NEG_X; u = -y; v = z;
                end
            end
            else if (ay >= az)
            begin
                m = ay;
                if (y > 0)
                begin
                    c.face = FACE_POS_Y; u = -x; v = z;
                end
                else
                begin
                    c.face = FACE_NEG_Y; u = x; v = z;
                end
            end
            else
            begin
                m = az;
                if (z > 0)
                begin
                    c.face = FACE_POS_Z; u = y; v = -x;
                end
                else
                begin
                    c.face = FACE_NEG_Z; u = y; v = x;
                end
            end
            c.cx = COORD_W'(quantise_coord(u, m, lvl));
            c.cy = COORD_W'(quantise_coord(v, m, lvl));
            c.st = ST_OK;
            c.id = (64'(c.face) << 61) | (64'(lvl) << 56) | (64'(c.cx) << 28) | 64'(c.cy);
            return c;
        end
    endfunction

    class cell_scoreboard;
        cell_t pending[$];
        int    errors;

        function void note_transfer(logic [31:0] dx, logic [31:0] dy,
                                    logic [31:0] dz, logic [4:0] lvl);
            pending.push_back(locate_cell(dx, dy, dz, lvl));
        endfunction

        function void check_cell(cell_t got);
            cell_t w;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer, id %h", got.id);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.id !== w.id)
            begin
                $error("cell_id expected %h actual %h", w.id, got.id); errors++;
            end
            if (got.face !== w.face)
            begin
                $error("cube_face expected %0d actual %0d", w.face, got.face); errors++;
            end
            if (got.cx !== w.cx)
            begin
                $error("cell_x expected %h actual %h", w.cx, got.cx); errors++;
            end
            if (got.cy !== w.cy)
            begin
                $error("cell_y expected %h actual %h", w.cy, got.cy); errors++;
            end
            if (got.st !== w.st)
            begin
                $error("status expected %0d actual %0d", w.st, got.st); errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        dir_x;
    logic [31:0]        dir_y;
    logic [31:0]        dir_z;
    logic [LEVEL_W-1:0] subdiv_level;
    logic               out_valid;
    logic               out_stall;
    logic [ID_W-1:0]    cell_id;
    logic [FACE_W-1:0]  cube_face;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         status;

    cell_scoreboard sb;
    bit             hold_off_rx;   // long receiver hold-off in progress

    cube_sphere_direction_to_cell_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .subdiv_level(subdiv_level),
        .out_valid(out_valid), .out_stall(out_stall),
        .cell_id(cell_id), .cube_face(cube_face),
        .cell_x(cell_x), .cell_y(cell_y), .status(status)
    );

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    // offer one direction and hold it until the transfer happens
    task automatic send_dir(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [4:0] lvl);
        int gap;
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                gap = 0;   // stretches with no idling
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid     <= 1'b1;
            dir_x        <= dx;
            dir_y        <= dy;
            dir_z        <= dz;
            subdiv_level <= lvl;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sb.note_transfer(dx, dy, dz, lvl);
        end
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 16)) - 8);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic [4:0]  lvl;
        begin
            dx = rand_comp();
            dy = rand_comp();
            dz = rand_comp();
            case ($urandom_range(0, 9))
                0: lvl = 5'($urandom_range(29, 31));
                1: lvl = 5'(MAX_LVL);
                2: lvl = 5'd0;
                default: lvl = 5'($urandom_range(0, MAX_LVL));
            endcase
            // ties between magnitudes exercise the face priority
            case ($urandom_range(0, 7))
                0: dy = dx;
                1: dz = -dy;
                2: begin dy = dx; dz = dx; end
                3: begin dx = '0; dy = '0; dz = '0; end
                default: ;
            endcase
            send_dir(dx, dy, dz, lvl);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off_rx)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 8) < $urandom_range(0, 8)) ? 1'b1 : 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_cell('{cell_id, cube_face, cell_x, cell_y, status});
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        dir_x        = '0;
        dir_y        = '0;
        dir_z        = '0;
        subdiv_level = '0;
        hold_off_rx  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each face, ties, far edge, both error kinds
        send_dir(32'd5, 32'd1, 32'd2, 5'd3);
        send_dir(-32'd5, 32'd1, 32'd2, 5'd3);
        send_dir(32'd1, 32'd7, -32'd3, 5'd4);
        send_dir(32'd1, -32'd7, -32'd3, 5'd4);
        send_dir(32'd1, 32'd2, 32'd9, 5'd10);
        send_dir(32'd1, 32'd2, -32'd9, 5'd10);
        send_dir(32'd4, 32'd4, 32'd4, 5'd28);
        send_dir(-32'd4, 32'd4, -32'd4, 5'd28);
        send_dir(32'd0, -32'd4, 32'd4, 5'd2);
        send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd28);
        send_dir(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 5'd28);
        send_dir(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 5'd1);
        send_dir(32'd10, 32'd10, -32'd10, 5'd0);
        send_dir(32'd3, 32'd3, 32'd3, 5'd5);
        send_dir(32'd0, 32'd0, 32'd0, 5'd7);
        send_dir(32'd0, 32'd0, 32'd0, 5'd31);
        send_dir(32'd1, 32'd0, 32'd0, 5'd29);
        send_dir(32'hffff_ffff, 32'h0, 32'h0, 5'd28);
        send_dir(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 5'd17);

        // receiver holds off while the sender keeps offering
        hold_off_rx = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off_rx = 1'b0;
            end
            repeat (40) send_random();
        join

        for (int i = 0; i < 1360; i++)
        begin
            send_random();
            if (i == 600)
            begin
                // sender pause until every expected cell has come
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
